// ===== src/wmma_pkg.sv =====
// Package for the weighted mean muscle activation block.
// Holds the payload structs, store and divider interface structs, the
// controller state type and the fixed-point constants. No dependencies.
package wmma_pkg;

  localparam int MUSCLES_DEF = 128;
  localparam int ADDR_W_MAX  = 10;
  localparam int SUM_W       = 48;
  localparam int WSUM_W      = 32;
  localparam int ACT_W       = 17;
  localparam int QUO_W       = 16;
  localparam int CFG_AW      = 3;

  localparam logic signed [15:0] REST_RESET    = 16'shBF00;
  localparam logic [14:0]        SCALE_RESET   = 15'd10240;
  localparam logic [14:0]        SCALE_DEFAULT = 15'd10240;
  localparam logic [ACT_W-1:0]   ONE_Q16       = 17'h10000;

  localparam logic REG_REST  = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [6:0]         muscle_number;
    logic [15:0]        edge_weight;
    logic               negative_sign;
    logic signed [15:0] neuron_voltage;
    logic               neuron_found;
  } in_item_t;

  typedef struct packed {
    logic [6:0]       read_muscle;
    logic [ACT_W-1:0] muscle_activation;
  } out_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] ssum;
    logic [WSUM_W-1:0]       wsum;
  } entry_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W_MAX-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W_MAX-1:0] addr;
    entry_t                data;
  } store_wr_t;

  typedef struct packed {
    logic              start;
    logic [WSUM_W-1:0] hi;
    logic [QUO_W-1:0]  lo;
    logic [WSUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_ACC
  } state_t;

endpackage

// ===== src/wmma_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, 16 bits of quotient.
// The dividend is {hi, lo} with hi below the divisor. Depends on wmma_pkg.
module wmma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wmma_pkg::div_req_t req,
  output wmma_pkg::div_rsp_t rsp
);
  import wmma_pkg::*;

  logic [WSUM_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [WSUM_W-1:0] div_r;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [WSUM_W:0]   shifted;
  logic [WSUM_W:0]   diff;

  always_comb begin
    shifted  = {rem_r, quo_r[QUO_W-1]};
    diff     = shifted - {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = req.hi;
      quo_nxt = req.lo;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (shifted >= {1'b0, div_r}) begin
        rem_nxt = diff[WSUM_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WSUM_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(QUO_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      div_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/wmma_store.sv =====
// Per-muscle accumulator store: one synchronous memory holding the signed sum
// and the weight sum, plus the clearing sweep that runs after reset. Depends on wmma_pkg.
module wmma_store #(
  parameter int MUSCLES = wmma_pkg::MUSCLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wmma_pkg::store_rd_t rd_req,
  input  wmma_pkg::store_wr_t wr_req,
  output wmma_pkg::entry_t    rd_data,
  output logic                clearing
);
  import wmma_pkg::*;

  localparam int AW = (MUSCLES > 1) ? $clog2(MUSCLES) : 1;

  entry_t          mem [MUSCLES];
  entry_t          rd_data_r;
  logic [AW-1:0]   clr_cnt_r;
  logic            clearing_r;
  logic            we;
  logic [AW-1:0]   wa;
  entry_t          wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == AW'(MUSCLES - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    if (clearing_r) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else begin
      we = wr_req.en;
      wa = wr_req.addr[AW-1:0];
      wd = wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr[AW-1:0]];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

// ===== src/weighted_mean_muscle_activation.sv =====
// Edge path: store read, divide for a fractional activation, multiply, accumulate, idle;
// a zero or full activation skips the divide and a skipped edge goes idle after the read.
// A read gives its result from the store read, or after the divide. One item at a time,
// paced by the 16-step shared divider. After reset the store is swept clean, one entry per
// cycle, with busy high during the sweep. Results appear for one cycle on out_strobe; the
// receiver cannot stall. Top level; uses wmma_pkg, wmma_store, wmma_div.
module weighted_mean_muscle_activation #(
  parameter int MUSCLES = wmma_pkg::MUSCLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Command channel: an item is transferred when start is high and busy is low.
  input  logic                         start,
  input  wmma_pkg::in_item_t           in_item,
  output logic                         busy,
  // Result channel: one cycle per result.
  output logic                         out_strobe,
  output wmma_pkg::out_item_t          out_item,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wmma_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import wmma_pkg::*;

  // Configuration registers. The register is chosen by the word address; the
  // low address bits are ignored and do not change the target.
  logic signed [15:0] rest_r;
  logic [14:0]        scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= REST_RESET;
      scale_r <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_REST:  rest_r  <= pwdata[15:0];
        REG_SCALE: scale_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REST:  prdata = {{16{rest_r[15]}}, rest_r};
      REG_SCALE: prdata = {17'd0, scale_r};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Controller state and item registers.
  state_t              state_r, state_nxt;
  in_item_t            item_r;
  logic                in_range_r;
  entry_t              entry_r, entry_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;
  logic [WSUM_W-1:0]   term_r;
  logic                out_strobe_r, out_strobe_nxt;
  out_item_t           out_item_r, out_item_nxt;

  store_rd_t           rd_req;
  store_wr_t           wr_req;
  entry_t              rd_data;
  logic                clearing;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                accept;
  logic                in_range_in;
  logic [14:0]         scale_eff;
  logic signed [16:0]  diff;
  logic                act_zero;
  logic                act_full;
  logic                mean_zero;
  logic                mean_full;
  logic                acc_go;
  logic                rd_go;
  logic                need_div;
  logic signed [SUM_W:0] sum_ext;
  logic [WSUM_W:0]     wsum_ext;
  logic [2*QUO_W:0]    product;

  assign busy        = (state_r != ST_IDLE);
  assign accept      = start && !busy;
  assign in_range_in = ({4'd0, in_item.muscle_number} < 11'(MUSCLES));

  wmma_store #(
    .MUSCLES (MUSCLES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_req   (rd_req),
    .wr_req   (wr_req),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  wmma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Edge activation from the latched voltage. A zero scale stands for 40 mV.
  // At or below rest the activation is zero; at or beyond a full scale it is one;
  // in between it is the quotient (diff << 16) / scale from the divider.
  always_comb begin
    scale_eff = (scale_r == '0) ? SCALE_DEFAULT : scale_r;
    diff      = 17'(item_r.neuron_voltage) - 17'(rest_r);
    act_zero  = diff[16] || (diff == '0);
    act_full  = !act_zero && (diff[15:0] >= {1'b0, scale_eff});
  end

  // Mean for a read, judged on the entry straight out of the store. A
  // non-positive sum or an empty weight sum reads as zero; a sum at or above
  // the weight sum times one reads as one; otherwise the divider runs.
  always_comb begin
    mean_zero = (rd_data.wsum == '0) || rd_data.ssum[SUM_W-1] || (rd_data.ssum == '0);
    mean_full = !mean_zero &&
                ($unsigned(rd_data.ssum) >= {rd_data.wsum, 16'h0000});
  end

  assign acc_go   = (item_r.operation == OP_ACCUM) && in_range_r && item_r.neuron_found;
  assign rd_go    = (item_r.operation == OP_READ) && in_range_r;
  assign need_div = acc_go ? (!act_zero && !act_full) : (rd_go && !mean_zero && !mean_full);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!clearing) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (need_div) begin
          state_nxt = ST_DIV;
        end else if (acc_go) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (item_r.operation == OP_ACCUM) ? ST_MUL : ST_IDLE;
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and store accesses for each state.
  always_comb begin
    rd_req.en      = accept && in_range_in;
    rd_req.addr    = {3'd0, in_item.muscle_number};
    wr_req.en      = 1'b0;
    wr_req.addr    = {3'd0, item_r.muscle_number};
    wr_req.data    = '0;
    div_req        = '0;
    entry_nxt      = entry_r;
    act_nxt        = act_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    sum_ext        = '0;
    wsum_ext       = '0;
    product        = 33'(item_r.edge_weight) * 33'(act_r);

    unique case (state_r)
      ST_LOAD: begin
        entry_nxt = rd_data;
        if (item_r.operation == OP_ACCUM) begin
          act_nxt = act_full ? ONE_Q16 : '0;
          if (acc_go && need_div) begin
            div_req.start   = 1'b1;
            div_req.hi      = {16'd0, diff[15:0]};
            div_req.lo      = '0;
            div_req.divisor = {17'd0, scale_eff};
          end
        end else begin
          // A read clears its entry right away; the divider keeps its own copy.
          wr_req.en = rd_go;
          if (need_div) begin
            div_req.start   = 1'b1;
            div_req.hi      = rd_data.ssum[SUM_W-1:QUO_W];
            div_req.lo      = rd_data.ssum[QUO_W-1:0];
            div_req.divisor = rd_data.wsum;
          end else begin
            out_strobe_nxt                 = 1'b1;
            out_item_nxt.read_muscle       = item_r.muscle_number;
            out_item_nxt.muscle_activation = (rd_go && mean_full) ? ONE_Q16 : '0;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (item_r.operation == OP_ACCUM) begin
            act_nxt = {1'b0, div_rsp.quotient};
          end else begin
            out_strobe_nxt                 = 1'b1;
            out_item_nxt.read_muscle       = item_r.muscle_number;
            out_item_nxt.muscle_activation = {1'b0, div_rsp.quotient};
          end
        end
      end
      ST_ACC: begin
        // Saturating updates of both sums.
        if (item_r.negative_sign) begin
          sum_ext = 49'(entry_r.ssum) - $signed({17'd0, term_r});
        end else begin
          sum_ext = 49'(entry_r.ssum) + $signed({17'd0, term_r});
        end
        wsum_ext  = {1'b0, entry_r.wsum} + 33'(item_r.edge_weight);
        wr_req.en = 1'b1;
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          wr_req.data.ssum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          wr_req.data.ssum = sum_ext[SUM_W-1:0];
        end
        wr_req.data.wsum = wsum_ext[WSUM_W] ? '1 : wsum_ext[WSUM_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= in_item;
      in_range_r <= in_range_in;
    end
    entry_r    <= entry_nxt;
    act_r      <= act_nxt;
    term_r     <= product[WSUM_W-1:0];
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Two results never follow in back-to-back cycles, since each needs an item
  // transferred in between.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("results issued in consecutive cycles");

  // No item may be taken while the store is still being swept.
  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy)
    else $error("block idle during clearing sweep");

  // The divider reports only while the controller waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside the divide state");

  // A transferred item always moves the controller to the store read.
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LOAD))
    else $error("transferred item did not start a store access");

endmodule
